@@ hw/rtl/signed_int_to_decimal_ascii_defines.svh @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_defines
// assertion macros shared by the decimal text converter
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define SITDA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while in reset
`define SITDA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sitda_pkg.sv @@
// ----------------------------------------------------------------------------
// sitda_pkg
// types and constants of the signed integer to decimal text converter
// ----------------------------------------------------------------------------
package sitda_pkg;

  // default width of the input value
  localparam int unsigned VALUE_BITS_DEF = 16;

  // longest text, sign included
  localparam int unsigned MAX_CHARS = 6;
  localparam int unsigned IDX_W     = $clog2(MAX_CHARS);
  localparam int unsigned CNT_W     = $clog2(MAX_CHARS + 1);

  // character and digit widths
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIG_W  = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // divide by ten as multiply by reciprocal, exact for values below 2**32
  localparam int unsigned RECIP_W     = 32;
  localparam logic [RECIP_W-1:0] RECIP = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIG  = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // take a new value, form its magnitude
    logic mul;   // register magnitude times reciprocal
    logic dig;   // store one digit, keep the quotient
    logic adv;   // current character taken, step to the next
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic more;  // another digit is to be extracted
    logic last;  // character on the output is the final one
  } sts_t;

endpackage

@@ hw/rtl/sitda_if.sv @@
// ----------------------------------------------------------------------------
// sitda_num_if / sitda_chr_if
// valid/ready channels for input values and output characters
// ----------------------------------------------------------------------------
interface sitda_num_if #(
  parameter int unsigned VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface sitda_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

@@ hw/rtl/sitda_ctrl.sv @@
// ----------------------------------------------------------------------------
// sitda_ctrl
// sequencer: accept, extract digits, hand out characters
// ----------------------------------------------------------------------------
module sitda_ctrl
  import sitda_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  state_e state_q, state_d;

  // handshakes follow the state
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);

  // next state and commands
  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIG;
      end
      S_DIG: begin
        cmd_o.dig = 1'b1;
        state_d   = sts_i.more ? S_MUL : S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          cmd_o.adv = 1'b1;
          if (sts_i.last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/sitda_dp.sv @@
// ----------------------------------------------------------------------------
// sitda_dp
// magnitude, divide-by-ten unit, digit store and character output
// ----------------------------------------------------------------------------
module sitda_dp
  import sitda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
)(
  input  logic                  clk_i,
  input  logic [VALUE_BITS-1:0] number_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic [CHAR_W-1:0]     ascii_char_o,
  output logic                  last_char_o
);

  localparam int unsigned PROD_W = VALUE_BITS + RECIP_W;

  logic [VALUE_BITS-1:0] mag_q;
  logic [PROD_W-1:0]     prod_q;
  logic                  neg_q;
  logic                  sign_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [IDX_W-1:0]      rd_q;
  logic [DIG_W-1:0]      digits_q [MAX_CHARS];

  logic [VALUE_BITS-1:0] mag_in;
  logic [VALUE_BITS-1:0] quot;
  logic [VALUE_BITS-1:0] quot10;
  logic [DIG_W-1:0]      rem;
  logic [CNT_W-1:0]      cnt_inc;
  logic [CNT_W-1:0]      avail;

  // unsigned magnitude, the most negative value included
  assign mag_in = number_i[VALUE_BITS-1] ? (~number_i + 1'b1) : number_i;

  // quotient and remainder from the registered product
  assign quot   = VALUE_BITS'(prod_q >> RECIP_SHIFT);
  assign quot10 = VALUE_BITS'({quot, 3'b000}) + VALUE_BITS'({quot, 1'b0});
  assign rem    = DIG_W'(mag_q - quot10);

  // room for digits after the sign
  assign cnt_inc = cnt_q + 1'b1;
  assign avail   = neg_q ? CNT_W'(MAX_CHARS - 1) : CNT_W'(MAX_CHARS);

  assign sts_o.more = (quot != '0) && (cnt_inc < avail);
  assign sts_o.last = !sign_q && (rd_q == '0);

  // character on the output, most significant digit first
  assign ascii_char_o = sign_q ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(digits_q[rd_q]));
  assign last_char_o  = sts_o.last;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q  <= mag_in;
      neg_q  <= number_i[VALUE_BITS-1];
      sign_q <= number_i[VALUE_BITS-1];
      cnt_q  <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(mag_q) * PROD_W'(RECIP);
    end
    if (cmd_i.dig) begin
      digits_q[cnt_q[IDX_W-1:0]] <= rem;
      mag_q                      <= quot;
      cnt_q                      <= cnt_inc;
      rd_q                       <= cnt_q[IDX_W-1:0];
    end
    if (cmd_i.adv) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        rd_q <= rd_q - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii.sv @@
// The first character is valid once all D digits of the accepted value are kept.
// Each digit takes two steps of the divide-by-ten unit: reciprocal multiply, then remainder.
// Characters then leave one per cycle while the sink is ready.
// A new value is accepted only once the last character of the previous value has left.
// Reset: asynchronous, active low; the sequencer returns to idle.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed integer in, decimal ASCII text out, one character per item
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii
  import sitda_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
)(
  input  logic       clk_i,
  input  logic       rst_ni,
  sitda_num_if.sink  in_i,
  sitda_chr_if.source out_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  sitda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath
  sitda_dp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .number_i     (in_i.number),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ascii_char_o (out_o.ascii_char),
    .last_char_o  (out_o.last_char)
  );

  // checks
  `SITDA_ASSERT_IMP(a_one_side, in_i.ready, !out_o.valid,
                    "input open while text pending")
  `SITDA_ASSERT_IMP(a_char_set, out_o.valid,
                    (out_o.ascii_char == CHAR_MINUS) ||
                    ((out_o.ascii_char >= CHAR_ZERO) &&
                     (out_o.ascii_char <= CHAR_ZERO + 8'd9)),
                    "character is neither sign nor digit")
  `SITDA_ASSERT_IMP(a_sign_not_last, out_o.valid && (out_o.ascii_char == CHAR_MINUS),
                    !out_o.last_char, "sign marked as last character")
  `SITDA_ASSERT_NXT(a_end_of_text, out_o.valid && out_o.ready && out_o.last_char,
                    !out_o.valid && in_i.ready, "text continues after last character")

endmodule
